// ===== hw/rtl/button_press_long_press_typematic_macros.svh =====
// Assertion macros for the button tracker.
// Included by the top level; needs nothing else.
`ifndef BUTTON_PRESS_LONG_PRESS_TYPEMATIC_MACROS_SVH
`define BUTTON_PRESS_LONG_PRESS_TYPEMATIC_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPLT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BPLT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bplt_pkg.sv =====
// Shared types and constants of the button tracker.
// No dependencies; used by every module in hw/rtl.
`timescale 1ns / 1ps

package bplt_pkg;

  localparam int NUM_BUTTONS = 4;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 2;
  localparam int LVL_W     = NUM_BUTTONS;
  localparam int COUNT_W   = 17;
  localparam int TICKS_W   = 16;
  localparam int MODE_W    = 2;
  localparam int MODES_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(20);
  localparam logic [COUNT_W-1:0] COUNT_TOP   = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MODES      = CFG_IDX_W'(0);
  localparam int                   REG_TICKS_BASE = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_PRS  = 2'd1,
    CMD_REL  = 2'd2,
    CMD_LONG = 2'd3
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_LONG   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_e;

  typedef struct packed {
    logic tick;
    logic level;
    logic clr_prs;
    logic clr_rel;
    logic clr_long;
  } btn_ctrl_t;

  typedef struct packed {
    logic prs;
    logic rel;
    logic lng;
  } btn_flags_t;

endpackage

// ===== hw/rtl/bplt_cfg.sv =====
// Configuration registers: button modes and per-button hold thresholds.
// Depends on bplt_pkg.
`timescale 1ns / 1ps

module bplt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bplt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bplt_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  output logic [bplt_pkg::MODES_W-1:0]     modes_o,
  output logic [bplt_pkg::TICKS_W-1:0]     ticks_o [bplt_pkg::NUM_BUTTONS]
);
  import bplt_pkg::*;

  logic [MODES_W-1:0] modes_q;
  logic [TICKS_W-1:0] ticks_q [NUM_BUTTONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == REG_MODES) begin
      modes_q <= cfg_wdata_i[MODES_W-1:0];
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_ticks
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ticks_q[i] <= TICKS_RESET;
      end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(REG_TICKS_BASE + i)) begin
        ticks_q[i] <= cfg_wdata_i[TICKS_W-1:0];
      end
    end
    assign ticks_o[i] = ticks_q[i];
  end

  assign modes_o = modes_q;

endmodule

// ===== hw/rtl/bplt_btn.sv =====
// State of one button: held bit, hold counter and sticky event flags.
// Depends on bplt_pkg.
`timescale 1ns / 1ps

module bplt_btn (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bplt_pkg::btn_ctrl_t            ctrl_i,
  input  logic [bplt_pkg::MODE_W-1:0]    mode_i,
  input  logic [bplt_pkg::TICKS_W-1:0]   thr_i,
  output bplt_pkg::btn_flags_t           flags_o
);
  import bplt_pkg::*;

  logic               held_q, held_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               prs_q, prs_d;
  logic               rel_q, rel_d;
  logic               lng_q, lng_d;

  logic [COUNT_W-1:0] inc;
  logic               hit;
  logic               first;

  assign inc = (cnt_q < COUNT_TOP) ? cnt_q + COUNT_W'(1) : cnt_q;
  assign hit = (inc == {1'b0, thr_i});

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    prs_d  = prs_q;
    rel_d  = rel_q;
    lng_d  = lng_q;
    first  = 1'b0;
    if (ctrl_i.tick) begin
      if (held_q && !ctrl_i.level) begin
        rel_d  = 1'b1;
        prs_d  = 1'b0;
        cnt_d  = '0;
        held_d = 1'b0;
      end else if (ctrl_i.level) begin
        unique case (mode_e'(mode_i))
          MODE_LONG: begin
            cnt_d = inc;
            if (hit) begin
              lng_d = 1'b1;
            end else begin
              first = !held_q;
            end
          end
          MODE_REPEAT: begin
            if (hit) begin
              prs_d = 1'b1;
              cnt_d = '0;
            end else begin
              cnt_d = inc;
              first = !held_q;
            end
          end
          default: begin
            first = !held_q;
          end
        endcase
        if (first) begin
          rel_d  = 1'b0;
          prs_d  = 1'b1;
          held_d = 1'b1;
        end
      end
    end else begin
      if (ctrl_i.clr_prs) begin
        prs_d = 1'b0;
      end
      if (ctrl_i.clr_rel) begin
        rel_d = 1'b0;
      end
      if (ctrl_i.clr_long) begin
        lng_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      cnt_q  <= '0;
      prs_q  <= 1'b0;
      rel_q  <= 1'b0;
      lng_q  <= 1'b0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      prs_q  <= prs_d;
      rel_q  <= rel_d;
      lng_q  <= lng_d;
    end
  end

  assign flags_o.prs = prs_q;
  assign flags_o.rel = rel_q;
  assign flags_o.lng = lng_q;

endmodule

// ===== hw/rtl/button_press_long_press_typematic.sv =====
// Push-button tracker with long-press detection and typematic repeat. It takes one
// beat per clock cycle: a beat lands in an input register; when it leaves that register, a
// tick beat updates every button's state, while a query beat puts the addressed button's
// flag in an output register and clears that flag, so a result passes both registers in
// turn. Tick beats give no result. Input stalls only while a query sits in the input
// register and the output register holds a result that the sink does not take.
// Depends on bplt_pkg, bplt_cfg, bplt_btn and the assertion macro header.
`timescale 1ns / 1ps

`include "button_press_long_press_typematic_macros.svh"

module button_press_long_press_typematic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bplt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bplt_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bplt_pkg::CMD_W-1:0]       cmd_i,
  input  logic [bplt_pkg::IDX_W-1:0]       button_index_i,
  input  logic [bplt_pkg::LVL_W-1:0]       pressed_levels_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             flag_o
);
  import bplt_pkg::*;

  logic               stage_valid_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LVL_W-1:0]   lvl_q;

  logic               out_valid_q, out_valid_d;
  logic               flag_q, flag_d;

  logic               stage_query;
  logic               stage_fire;
  logic               in_fire;
  logic               idx_ok;
  logic               sel_flag;

  logic [MODES_W-1:0] modes;
  logic [TICKS_W-1:0] ticks [NUM_BUTTONS];
  btn_ctrl_t          ctrl  [NUM_BUTTONS];
  btn_flags_t         flags [NUM_BUTTONS];

  bplt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .modes_o     (modes),
    .ticks_o     (ticks)
  );

  assign stage_query = (cmd_e'(cmd_q) != CMD_TICK);
  assign stage_fire  = stage_valid_q && (!stage_query || !out_valid_q || out_ready_i);
  assign in_ready_o  = !stage_valid_q || stage_fire;
  assign in_fire     = in_valid_i && in_ready_o;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic addr_hit;
    assign addr_hit         = stage_fire && (idx_q == IDX_W'(i));
    assign ctrl[i].tick     = stage_fire && (cmd_e'(cmd_q) == CMD_TICK);
    assign ctrl[i].level    = lvl_q[i];
    assign ctrl[i].clr_prs  = addr_hit && (cmd_e'(cmd_q) == CMD_PRS);
    assign ctrl[i].clr_rel  = addr_hit && (cmd_e'(cmd_q) == CMD_REL);
    assign ctrl[i].clr_long = addr_hit && (cmd_e'(cmd_q) == CMD_LONG);

    bplt_btn u_btn (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .mode_i  (modes[MODE_W*i +: MODE_W]),
      .thr_i   (ticks[i]),
      .flags_o (flags[i])
    );
  end

  assign idx_ok = (int'(idx_q) < NUM_BUTTONS);

  always_comb begin
    sel_flag = 1'b0;
    if (idx_ok) begin
      unique case (cmd_e'(cmd_q))
        CMD_PRS:  sel_flag = flags[idx_q].prs;
        CMD_REL:  sel_flag = flags[idx_q].rel;
        CMD_LONG: sel_flag = flags[idx_q].lng;
        default:  sel_flag = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    flag_d      = flag_q;
    if (stage_fire && stage_query) begin
      out_valid_d = 1'b1;
      flag_d      = sel_flag;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        stage_valid_q <= 1'b1;
      end else if (stage_fire) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    if (in_fire) begin
      cmd_q <= cmd_i;
      idx_q <= button_index_i;
      lvl_q <= pressed_levels_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flag_o      = flag_q;

  `BPLT_ASSERT(a_query_gives_result, clk_i, rst_ni, stage_fire && stage_query |=> out_valid_o, "query beat left no result")
  `BPLT_ASSERT(a_result_from_query, clk_i, rst_ni, $rose(out_valid_o) |-> $past(stage_fire && stage_query), "result without query beat")
  `BPLT_ASSERT_ALWAYS(a_stall_needs_item, clk_i, !in_ready_o |-> stage_valid_q, "input stalled with empty stage")

endmodule
